// ----- src/rle26_pkg.sv -----
`default_nettype none
package rle26_pkg;

    localparam int unsigned MAX_RUN_DEFAULT = 675;

    localparam int unsigned VALUE_W   = 5;
    localparam int unsigned LEN_W     = 10;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned RUN_CHARS = 3;
    localparam int unsigned SLOTS     = 5;
    localparam int unsigned SLOT_IDX_W = $clog2(SLOTS);

    localparam logic [CHAR_W-1:0] CH_COUNT_BASE = 8'd97;
    localparam logic [CHAR_W-1:0] CH_VALUE_BASE = 8'd65;
    localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'd10;
    localparam logic [LEN_W-1:0]  ONE_LETTER_MAX = 10'd25;
    localparam logic [4:0]        RADIX          = 5'd26;

    // 2521 / 65536 approximates 1/26 closely enough for every 10-bit length.
    localparam logic [11:0] RECIP_26 = 12'd2521;
    localparam int unsigned RECIP_SHIFT = 16;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [CHAR_W-1:0]  t_char;

    typedef struct packed {
        logic [RUN_CHARS-1:0][CHAR_W-1:0] ch;
        logic [1:0]                       cnt;
    } t_run_text;

    typedef struct packed {
        logic [SLOTS-1:0][CHAR_W-1:0] ch;
        logic [SLOT_IDX_W-1:0]        cnt;
    } t_burst;

    // Text for one run: high count letter, low count letter, value letter,
    // with the count letters dropped for short runs. ch[0] goes out first.
    function automatic t_run_text run_text(input t_len len, input t_value val);
        t_run_text  res;
        logic [21:0] prod;
        logic [4:0]  quo;
        logic [9:0]  qx26;
        logic [4:0]  rem;
        t_char       hi_ch;
        t_char       lo_ch;
        t_char       val_ch;
        prod   = {12'd0, len} * {10'd0, RECIP_26};
        quo    = 5'(prod >> RECIP_SHIFT);
        qx26   = 10'({5'd0, quo} * {5'd0, RADIX});
        rem    = 5'(len - qx26);
        hi_ch  = CH_COUNT_BASE + {3'd0, quo};
        lo_ch  = CH_COUNT_BASE + {3'd0, rem};
        val_ch = CH_VALUE_BASE + {3'd0, val};
        res.ch = '0;
        if (len > ONE_LETTER_MAX) begin
            res.ch[0] = hi_ch;
            res.ch[1] = lo_ch;
            res.ch[2] = val_ch;
            res.cnt   = 2'd3;
        end else if (len > 10'd1) begin
            res.ch[0] = lo_ch;
            res.ch[1] = val_ch;
            res.cnt   = 2'd2;
        end else begin
            res.ch[0] = val_ch;
            res.cnt   = 2'd1;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- src/rle26_run_stage.sv -----
`default_nettype none
module rle26_run_stage #(
    parameter int unsigned MAX_RUN = rle26_pkg::MAX_RUN_DEFAULT
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_accept,
    input  wire rle26_pkg::t_value i_tile_value,
    input  wire                    i_row_end,
    output rle26_pkg::t_burst      o_burst
);
    import rle26_pkg::*;

    localparam t_len MaxLen = LEN_W'(MAX_RUN);

    t_value    r_run_value;
    t_len      r_run_length;
    t_value    n_run_value;
    t_len      n_run_length;

    logic      run_open;
    logic      run_break;
    t_len      grown_len;
    logic      close_run;
    t_run_text old_text;
    t_run_text new_text;
    logic [1:0] na;
    logic [1:0] nb;
    logic      nl;

    always_comb begin
        run_open  = (r_run_length != '0);
        run_break = run_open && (i_tile_value != r_run_value);

        if (!run_open || run_break) begin
            n_run_value = i_tile_value;
            grown_len   = 10'd1;
        end else begin
            n_run_value = r_run_value;
            grown_len   = r_run_length + 10'd1;
        end

        close_run    = (grown_len >= MaxLen) || i_row_end;
        n_run_length = close_run ? '0 : grown_len;

        old_text = run_text(r_run_length, r_run_value);
        new_text = run_text(grown_len, n_run_value);
        na = run_break ? old_text.cnt : 2'd0;
        nb = close_run ? new_text.cnt : 2'd0;
        nl = i_row_end;
    end

    // Pack the closed old run, the closed current run and the newline into
    // consecutive slots.
    always_comb begin
        logic [SLOT_IDX_W-1:0] idx;
        logic [SLOT_IDX_W-1:0] off;
        o_burst.ch = '0;
        for (int i = 0; i < SLOTS; i++) begin
            idx = SLOT_IDX_W'(i);
            off = idx - {1'b0, na};
            if (idx < {1'b0, na}) begin
                o_burst.ch[i] = old_text.ch[idx[1:0]];
            end else if (off < {1'b0, nb}) begin
                o_burst.ch[i] = new_text.ch[off[1:0]];
            end else begin
                o_burst.ch[i] = CH_NEWLINE;
            end
        end
        o_burst.cnt = {1'b0, na} + {1'b0, nb} + {2'd0, nl};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_value  <= '0;
            r_run_length <= '0;
        end else if (i_accept) begin
            r_run_value  <= n_run_value;
            r_run_length <= n_run_length;
        end
    end

    a_len_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_length < MaxLen)
        else $error("open run reached the maximum length");

    a_row_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_row_end |=> r_run_length == '0)
        else $error("row end left a run open");

    a_burst_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_burst.cnt <= SLOT_IDX_W'(SLOTS))
        else $error("burst exceeds slot count");

endmodule
`default_nettype wire

// ----- src/rle26_burst_out.sv -----
`default_nettype none
module rle26_burst_out (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_load,
    input  wire rle26_pkg::t_burst i_burst,
    output logic                   o_free,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output rle26_pkg::t_char       o_text_char,
    output logic                   o_burst_last
);
    import rle26_pkg::*;

    logic [SLOTS-1:0][CHAR_W-1:0] r_chars;
    logic [SLOT_IDX_W-1:0]        r_cnt;
    logic [SLOT_IDX_W-1:0]        r_idx;
    logic                         r_busy;

    logic take;
    logic at_last;

    assign at_last      = (r_idx == r_cnt - SLOT_IDX_W'(1));
    assign take         = r_busy && !i_out_stall;
    assign o_free       = !r_busy || (take && at_last);
    assign o_out_valid  = r_busy;
    assign o_text_char  = r_chars[r_idx];
    assign o_burst_last = at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_cnt  <= '0;
        end else if (i_load) begin
            // The caller loads only when o_free is high.
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_cnt  <= i_burst.cnt;
        end else if (take) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + SLOT_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_chars <= i_burst.ch;
        end
    end

    a_idx_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0) && (r_idx < r_cnt))
        else $error("character index outside the loaded burst");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free && (i_burst.cnt != '0))
        else $error("burst loaded over a pending one");

    a_step_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !at_last |=> r_busy && (r_idx == $past(r_idx) + SLOT_IDX_W'(1)))
        else $error("serializer did not advance");

endmodule
`default_nettype wire

// ----- src/rle_row_encoder_base26_core.sv -----
// Run-length row encoder with base-26 text output.
// Input channel: i_in_valid / o_in_stall carry one tile beat (i_tile_value,
// i_row_end). Output channel: o_out_valid / i_out_stall carry one character
// beat (o_text_char, o_burst_last). A beat moves on a rising edge where
// valid is high and stall is low.
// An accepted tile updates the open run in the same cycle and, when it
// closes a run or ends a row, loads a burst of one to five characters into
// the output register. The first character is valid the cycle after the tile
// is taken; the rest follow one per cycle while the receiver does not stall,
// and o_burst_last marks the final character of the burst.
// A tile that only extends a run produces no character; such tiles flow at
// one per cycle while no burst is pending. A tile that produces characters
// holds the output register until its last character leaves; the next tile is
// taken in the cycle the last character of the previous burst leaves, so a
// stall-free one-character-per-tile stream also runs at one tile per cycle.
// o_in_stall is high while a burst is pending and its last character cannot
// leave in that cycle, whether or not the next tile produces characters.
// When the receiver stalls, the pending character holds.
// Reset (i_rst_n low, synchronous) closes any open run and drops any
// pending characters.
`default_nettype none
module rle_row_encoder_base26_core #(
    parameter int unsigned MAX_RUN = rle26_pkg::MAX_RUN_DEFAULT
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire rle26_pkg::t_value i_tile_value,
    input  wire                    i_row_end,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output rle26_pkg::t_char       o_text_char,
    output logic                   o_burst_last
);
    import rle26_pkg::*;

    t_burst burst;
    logic   out_free;
    logic   in_accept;
    logic   load;

    assign o_in_stall = !out_free;
    assign in_accept  = i_in_valid && out_free;
    assign load       = in_accept && (burst.cnt != '0);

    rle26_run_stage #(
        .MAX_RUN (MAX_RUN)
    ) u_run_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_tile_value (i_tile_value),
        .i_row_end    (i_row_end),
        .o_burst      (burst)
    );

    rle26_burst_out u_burst_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_burst      (burst),
        .o_free       (out_free),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_text_char  (o_text_char),
        .o_burst_last (o_burst_last)
    );

endmodule
`default_nettype wire

// ----- sim/rle26_text_checker.sv -----
`timescale 1ns / 1ps

module rle26_text_checker #(
    parameter int unsigned MAX_RUN = rle26_pkg::MAX_RUN_DEFAULT
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire                    i_in_stall,
    input  wire rle26_pkg::t_value i_tile_value,
    input  wire                    i_row_end,
    input  wire                    i_out_valid,
    input  wire                    i_out_stall,
    input  wire rle26_pkg::t_char  i_text_char,
    input  wire                    i_burst_last,
    output int                     o_error_count,
    output int                     o_chars_pending
);
    import rle26_pkg::*;

    typedef struct packed {
        t_char ch;
        logic  last;
    } t_text_beat;

    t_text_beat pending_chars[$];
    t_value     open_value = '0;
    t_len       open_len = '0;

    initial o_error_count = 0;
    initial o_chars_pending = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_error_count++;
    endtask

    function automatic void queue_char(input t_char ch);
        pending_chars.push_back('{ch: ch, last: 1'b0});
    endfunction

    // Spell out the open run as count letters and a value letter, then close it.
    function automatic void close_run();
        if (open_len > ONE_LETTER_MAX) begin
            queue_char(CH_COUNT_BASE + t_char'(open_len / RADIX));
        end
        if (open_len > t_len'(1)) begin
            queue_char(CH_COUNT_BASE + t_char'(open_len % RADIX));
        end
        queue_char(CH_VALUE_BASE + t_char'(open_value));
        open_len = '0;
    endfunction

    function automatic void encode_tile(input t_value val, input logic row_done);
        int n_start;
        n_start = pending_chars.size();
        if (open_len != '0 && val != open_value) begin
            close_run();
        end
        if (open_len == '0) begin
            open_value = val;
            open_len = t_len'(1);
        end else begin
            open_len = open_len + t_len'(1);
        end
        if (open_len >= t_len'(MAX_RUN)) begin
            close_run();
        end
        if (row_done) begin
            if (open_len != '0) begin
                close_run();
            end
            queue_char(CH_NEWLINE);
        end
        if (pending_chars.size() > n_start) begin
            pending_chars[pending_chars.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic check_char(input t_char ch, input logic last);
        t_text_beat want;
        if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("character %0d with nothing expected", ch));
        end else begin
            want = pending_chars.pop_front();
            if (ch !== want.ch) begin
                report_mismatch($sformatf("text_char %0d, expected %0d", ch, want.ch));
            end
            if (last !== want.last) begin
                report_mismatch($sformatf("burst_last %0b, expected %0b on char %0d",
                                          last, want.last, want.ch));
            end
        end
    endtask

    // Output beats always come from tiles taken at earlier edges, so the
    // character is checked before the tile of the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            open_value = '0;
            open_len = '0;
            pending_chars.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_char(i_text_char, i_burst_last);
            end
            if (i_in_valid && !i_in_stall) begin
                encode_tile(i_tile_value, i_row_end);
            end
        end
        o_chars_pending = pending_chars.size();
    end

endmodule

// ----- sim/rle_row_encoder_base26_core_test.sv -----
`timescale 1ns / 1ps

module rle_row_encoder_base26_core_test;
    import rle26_pkg::*;

    localparam int unsigned RUN_LIMIT = MAX_RUN_DEFAULT;
    localparam int QUIET_LIMIT = 2000;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    t_value tile_value = '0;
    logic   row_end = 1'b0;
    logic   out_stall = 1'b0;
    logic   in_stall;
    logic   out_valid;
    t_char  text_char;
    logic   burst_last;

    int error_count;
    int chars_pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int tiles_sent = 0;
    int quiet_cycles = 0;

    rle_row_encoder_base26_core #(
        .MAX_RUN(RUN_LIMIT)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_tile_value(tile_value),
        .i_row_end   (row_end),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_text_char (text_char),
        .o_burst_last(burst_last)
    );

    rle26_text_checker #(
        .MAX_RUN(RUN_LIMIT)
    ) text_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_tile_value   (tile_value),
        .i_row_end      (row_end),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_text_char    (text_char),
        .i_burst_last   (burst_last),
        .o_error_count  (error_count),
        .o_chars_pending(chars_pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d characters outstanding",
                         quiet_cycles, chars_pending);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Called and returning at a falling edge; valid stays high between
    // back-to-back beats.
    task automatic push_tile(input t_value val, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        tile_value <= val;
        row_end <= last;
        do @(posedge clk); while (in_stall);
        tiles_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (chars_pending != 0);
    endtask

    task automatic send_run(input t_value val, input int len, input logic end_row);
        for (int j = 0; j < len; j++) begin
            push_tile(val, end_row && (j == len - 1));
        end
    endtask

    // Mostly legal tile values, now and then one of the unused codes above 25.
    function automatic t_value pick_value();
        if ($urandom_range(99) < 88) begin
            return t_value'($urandom_range(25));
        end
        return t_value'($urandom_range(31));
    endfunction

    task automatic send_row();
        int n_runs;
        int len;
        int r;
        t_value val;
        n_runs = $urandom_range(1, 6);
        for (int k = 0; k < n_runs; k++) begin
            val = pick_value();
            r = $urandom_range(99);
            if (r < 40) begin
                len = 1;
            end else if (r < 65) begin
                len = $urandom_range(2, 5);
            end else if (r < 85) begin
                // Around the switch from one count letter to two.
                len = $urandom_range(24, 28);
            end else begin
                len = $urandom_range(6, 60);
            end
            send_run(val, len, k == n_runs - 1);
        end
    endtask

    initial begin
        int goal;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 36;
        recv_stall_pct = 45;

        // Short directed sequence: single tiles, pairs, value changes, codes
        // above 25, and a row end right after a row end.
        push_tile(5'd0, 1'b1);
        send_run(5'd25, 2, 1'b0);
        send_run(5'd31, 2, 1'b1);
        push_tile(5'd16, 1'b0);
        push_tile(5'd5, 1'b1);
        send_run(5'd7, 3, 1'b1);
        push_tile(5'd10, 1'b1);
        push_tile(5'd10, 1'b1);
        push_tile(5'd30, 1'b0);
        push_tile(5'd1, 1'b0);
        push_tile(5'd26, 1'b0);
        push_tile(5'd15, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 36;
                    recv_stall_pct = 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_stall_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    // A long run then a one-tile run ending the row: five chars.
                    send_run(5'd3, 27, 1'b0);
                    push_tile(5'd9, 1'b1);
                end
            endcase
            goal = tiles_sent + 90;
            while (tiles_sent < goal) begin
                if ($urandom_range(9) == 0) begin
                    // Noise: loose tiles with random row ends.
                    repeat ($urandom_range(1, 8)) begin
                        push_tile(t_value'($urandom_range(31)), $urandom_range(2) == 0);
                    end
                end else begin
                    send_row();
                end
            end
            wait_drained();
        end

        repeat (10) @(negedge clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/rle26_pkg.sv
src/rle26_run_stage.sv
src/rle26_burst_out.sv
src/rle_row_encoder_base26_core.sv
sim/rle26_text_checker.sv
sim/rle_row_encoder_base26_core_test.sv
